>>> sv/rms_pkg.sv
package rms_pkg;

  localparam int VALUE_W = 32;
  localparam int MAX_ELEMENTS_DEF = 64;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      final_res;
  } out_word_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> sv/rms_cell.sv
module rms_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  rms_pkg::cell_ctrl_t               ctrl,
  input  logic signed [rms_pkg::VALUE_W-1:0] value,
  input  logic                              prev_gt,
  input  logic signed [rms_pkg::VALUE_W-1:0] prev_data,
  input  logic                              prev_valid,
  input  logic signed [rms_pkg::VALUE_W-1:0] next_data,
  input  logic                              next_valid,
  output logic signed [rms_pkg::VALUE_W-1:0] data,
  output logic                              valid,
  output logic                              gt
);

  // cell yields its place when empty or holding a larger value
  assign gt = !valid || (value < data);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (gt) begin
        valid <= prev_gt ? prev_valid : 1'b1;
      end
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (gt) begin
        data <= prev_gt ? prev_data : value;
      end
    end else if (ctrl.shift) begin
      data <= next_data;
    end
  end

endmodule

>>> sv/run_merge_sorter.sv
// run_merge_sorter: sorts a set of signed 32-bit words in ascending order.
// input channel (data_valid, data_stall, data): one word per cycle while
// data_stall is low, each with a last mark; the set ends on a word marked
// last or on its MAX_ELEMENTS-th word, whichever comes first.
// each word is inserted into a chain of cells kept in sorted order; the set
// is held in the cells themselves.
// output channel (result_valid, result_stall, result): from the cycle after
// the closing word, the set comes out smallest first, one word per cycle while
// result_stall is low, by shifting the chain towards its head; final_res marks
// the largest word.
// data_stall is high while a set is being emitted; a new set starts once the
// final word has been taken.
// a stalled result holds its word, and the chain does not move.
// reset empties the chain and leaves the block ready for a new set.
module run_merge_sorter #(
  parameter int MAX_ELEMENTS = rms_pkg::MAX_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_stall,
  input  rms_pkg::in_word_t  data,
  output logic               result_valid,
  input  logic               result_stall,
  output rms_pkg::out_word_t result
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic                              unloading;
  logic [CNT_W-1:0]                  count;
  rms_pkg::cell_ctrl_t               ctrl;
  logic signed [rms_pkg::VALUE_W-1:0] cell_data [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0]           cell_valid;
  logic [MAX_ELEMENTS-1:0]           cell_gt;

  assign ctrl.insert = data_valid && !unloading;
  assign ctrl.shift  = result_valid && !result_stall;

  assign data_stall          = unloading;
  assign result_valid        = unloading;
  assign result.sorted_value = cell_data[0];
  assign result.final_res    = (count == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      unloading <= 1'b0;
    end else if (ctrl.insert) begin
      count <= count + CNT_W'(1);
      if (data.last || count == CNT_W'(MAX_ELEMENTS - 1)) begin
        unloading <= 1'b1;
      end
    end else if (ctrl.shift) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        unloading <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic                              prev_gt;
    logic signed [rms_pkg::VALUE_W-1:0] prev_data;
    logic                              prev_valid;
    logic signed [rms_pkg::VALUE_W-1:0] next_data;
    logic                              next_valid;

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_data  = '0;
      assign prev_valid = 1'b0;
    end else begin : g_body
      assign prev_gt    = cell_gt[i-1];
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end

    rms_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .value      (data.value),
      .prev_gt    (prev_gt),
      .prev_data  (prev_data),
      .prev_valid (prev_valid),
      .next_data  (next_data),
      .next_valid (next_valid),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i])
    );
  end

`ifndef SYNTH
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell occupancy differs from count");

  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("occupied cells not packed at head of chain");

  a_ascending: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift && !result.final_res |=>
      result_valid && (result.sorted_value >= $past(result.sorted_value)))
    else $error("results out of order");

  a_final_ends_set: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift && result.final_res |=> !result_valid && count == '0)
    else $error("set not closed after final word");
`endif

endmodule
